FILE: src/wlmf_pkg.sv
// Package for the window local minima finder.
// Holds payload structs, window geometry constants and inter-module structs.
// No dependencies.
package wlmf_pkg;

   // Window geometry: columns and rows x-REACH..x+REACH-1
   localparam int REACH      = 3;
   localparam int WIN        = 2 * REACH;
   localparam int STORE_ROWS = WIN - 1;

   localparam int VALUE_W = 16;
   localparam int INDEX_W = 20;
   localparam int SIZE_W  = 11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Result queue depth, must hold at least REACH entries
   localparam int FIFO_DEPTH = 8;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_DRAIN  = 1'b1;

   typedef enum logic {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] error_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] minimum_index;
      logic               last_of_run;
   } rsp_type;

   // Per-item geometry handed to the window compare
   typedef struct packed {
      logic [WIN-1:0]     row_ok;
      logic [WIN-1:0]     col_ok;
      logic [REACH-1:0]   cand_en;
      logic [INDEX_W-1:0] base_index;
   } job_type;

   // Outcome of one item: which candidates are minima
   typedef struct packed {
      logic [REACH-1:0]   hit;
      logic [INDEX_W-1:0] base_index;
   } hits_type;

endpackage

FILE: src/wlmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read and write to one address return the old contents.
// No dependencies.
module wlmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/wlmf_window.sv
// Sliding 2*REACH square window register and parallel minimum compares.
// Depends on wlmf_pkg.
module wlmf_window (
   input  logic                                          clock,
   input  logic                                          advance,
   input  logic [wlmf_pkg::WIN-1:0][wlmf_pkg::VALUE_W-1:0] column,
   input  wlmf_pkg::job_type                             job,
   output wlmf_pkg::hits_type                            hits
);

   localparam int WIN   = wlmf_pkg::WIN;
   localparam int REACH = wlmf_pkg::REACH;

   logic [WIN-1:0][WIN-1:0][wlmf_pkg::VALUE_W-1:0] win_ff;
   logic [WIN-1:0][WIN-1:0][wlmf_pkg::VALUE_W-1:0] win_in;
   logic [REACH-1:0]                               is_min;

   // Shift left, new column enters at the right
   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         for (int k = 0; k < WIN - 1; k++) begin
            win_in[j][k] = win_ff[j][k+1];
         end
         win_in[j][WIN-1] = column[j];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff <= win_in;
      end
   end

   // Candidate i sits at row REACH, column REACH+i; in-map cells strictly
   // below it disqualify it
   always_comb begin
      for (int i = 0; i < REACH; i++) begin
         is_min[i] = 1'b1;
         for (int j = 0; j < WIN; j++) begin
            for (int k = 0; k < WIN; k++) begin
               if ((k >= i) && !((j == REACH) && (k == REACH + i))) begin
                  if (job.row_ok[j] && job.col_ok[k] &&
                      (win_in[j][k] < win_in[REACH][REACH+i])) begin
                     is_min[i] = 1'b0;
                  end
               end
            end
         end
      end
   end

   assign hits.hit        = job.cand_en & is_min;
   assign hits.base_index = job.base_index;

endmodule

FILE: src/wlmf_result_fifo.sv
// Result queue: takes up to REACH results per cycle, sends one per transfer.
// Depends on wlmf_pkg.
module wlmf_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wlmf_pkg::hits_type hits,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wlmf_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = wlmf_pkg::FIFO_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int REACH = wlmf_pkg::REACH;

   wlmf_pkg::rsp_type fifo_ff [DEPTH];
   wlmf_pkg::rsp_type fifo_in [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]       count_ff, count_in;
   logic [PW:0]       n_push;
   logic [PW-1:0]     slot;
   logic              pop;
   logic              later;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ff];
   assign room      = (32'(count_ff) <= DEPTH - REACH);

   // Pack hits in candidate order; last flag on the final one
   always_comb begin
      fifo_in = fifo_ff;
      n_push  = '0;
      for (int i = 0; i < REACH; i++) begin
         later = 1'b0;
         for (int m = i + 1; m < REACH; m++) begin
            later = later | hits.hit[m];
         end
         slot = PW'(wr_ff + PW'(n_push));
         if (push && hits.hit[i]) begin
            fifo_in[slot].minimum_index = wlmf_pkg::INDEX_W'(hits.base_index +
                                          wlmf_pkg::INDEX_W'(i));
            fifo_in[slot].last_of_run   = !later;
            n_push = n_push + 1'b1;
         end
      end
      wr_in    = PW'(wr_ff + PW'(n_push));
      rd_in    = pop ? PW'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + n_push - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("result queue overfilled");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push && (hits.hit != '0)) |-> room)
      else $error("results pushed without room");
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PW'(wr_ff - rd_ff) == PW'(count_ff))
      else $error("queue pointers disagree with count");

endmodule

FILE: src/window_local_minima_finder.sv
// Window local minima finder top level.
// Depends on wlmf_pkg, wlmf_ram, wlmf_window, wlmf_result_fifo.
//
// Cells of an error map enter on req_* in raster order, one per transfer;
// after the frame the host sends (REACH-1) rows of drain items (mode 1).
// A drain item inside the frame or a sample during the drain rows is taken
// and dropped. Every cell that no in-map cell of its window undercuts is
// reported on rsp_* as its raster index; last_of_run marks the final result
// of one input item (up to REACH results at the end of a row).
// Throughput: one input item per clock while req_stall is low. An item's
// line store read and item register are taken at its transfer; the window
// compare then puts its results into the result queue once the queue has
// room, and they are offered on rsp_* from there. Results leave the queue
// one per cycle while rsp_stall is low.
// When rsp_stall holds, the queue of FIFO_DEPTH entries fills and req_stall
// rises once fewer than REACH places remain.
// Reset empties the queue, restarts the frame at cell 0 and sets both map
// sizes to 1024 (clamped to the parameters). A write to either size register
// also restarts the frame. The line store needs no clearing.
module window_local_minima_finder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wlmf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wlmf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wlmf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wlmf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wlmf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int REACH   = wlmf_pkg::REACH;
   localparam int WIN     = wlmf_pkg::WIN;
   localparam int ROWS    = wlmf_pkg::STORE_ROWS;
   localparam int SIZE_W  = wlmf_pkg::SIZE_W;
   localparam int INDEX_W = wlmf_pkg::INDEX_W;
   localparam int VALUE_W = wlmf_pkg::VALUE_W;
   localparam int COLW    = $clog2(MAX_WIDTH);
   localparam int RW      = $clog2(MAX_HEIGHT + REACH);
   localparam int SELW    = $clog2(ROWS);

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > hi) begin
         r = SIZE_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [SIZE_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic [COLW-1:0]    col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [SELW-1:0]    sel_ff, sel_in;
   logic [INDEX_W-1:0] row_base_ff, row_base_in;
   logic               s1_valid_ff, s1_valid_in;
   wlmf_pkg::job_type  s1_job_ff, job_in;
   logic [VALUE_W-1:0] s1_val_ff;
   logic [SELW-1:0]    s1_sel_ff;

   logic               csr_wr;
   logic               in_frame, act, accept, load, room, advance, last_col;
   logic [ROWS-1:0][VALUE_W-1:0]          ram_rdata;
   logic [WIN-1:0][VALUE_W-1:0]           column;
   wlmf_pkg::hits_type                    hits;
   logic [SELW:0]                         rot;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == wlmf_pkg::REG_MAP_HEIGHT) ?
                       wlmf_pkg::CSR_DATA_W'(height_ff) : wlmf_pkg::CSR_DATA_W'(width_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (wlmf_pkg::reg_index_type'(csr_paddr[2]))
            wlmf_pkg::REG_MAP_WIDTH:  width_in  = clamp_size(csr_pwdata[SIZE_W-1:0], MAX_WIDTH);
            wlmf_pkg::REG_MAP_HEIGHT: height_in = clamp_size(csr_pwdata[SIZE_W-1:0], MAX_HEIGHT);
            default: ;
         endcase
      end
   end

   // Input acceptance
   assign in_frame  = (32'(row_ff) < 32'(height_ff));
   assign act       = ((req_data.mode == wlmf_pkg::MODE_SAMPLE) == in_frame);
   assign req_stall = s1_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && act;
   assign advance   = s1_valid_ff && room;
   assign last_col  = (32'(col_ff) == 32'(width_ff) - 1);

   // Arrival position counters
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      sel_in      = sel_ff;
      row_base_in = row_base_ff;
      if (csr_wr) begin
         col_in      = '0;
         row_in      = '0;
         sel_in      = '0;
         row_base_in = '0;
      end else if (load) begin
         if (last_col) begin
            col_in      = '0;
            row_in      = RW'(row_ff + 1'b1);
            row_base_in = INDEX_W'(row_base_ff + INDEX_W'(width_ff));
            sel_in      = (32'(sel_ff) == ROWS - 1) ? '0 : SELW'(sel_ff + 1'b1);
            if (32'(row_ff) + 1 >= 32'(height_ff) + REACH - 1) begin
               row_in      = '0;
               row_base_in = '0;
               sel_in      = '0;
            end
         end else begin
            col_in = COLW'(col_ff + 1'b1);
         end
      end
   end

   // Window geometry for this item
   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         job_in.row_ok[j] = (32'(row_ff) + j >= WIN - 1) &&
                            (32'(row_ff) + j < 32'(height_ff) + WIN - 1);
      end
      for (int k = 0; k < WIN; k++) begin
         job_in.col_ok[k] = (32'(col_ff) + k >= WIN - 1) &&
                            (32'(col_ff) + k < 32'(width_ff) + WIN - 1);
      end
      for (int i = 0; i < REACH; i++) begin
         if (i == 0) begin
            job_in.cand_en[i] = (32'(row_ff) >= REACH - 1) && (32'(col_ff) >= REACH - 1);
         end else begin
            job_in.cand_en[i] = (32'(row_ff) >= REACH - 1) && last_col &&
                                (32'(col_ff) + i >= REACH - 1);
         end
      end
      job_in.base_index = INDEX_W'(row_base_ff - INDEX_W'(width_ff) * INDEX_W'(REACH - 1) +
                                   INDEX_W'(col_ff) - INDEX_W'(REACH - 1));
   end

   // Item register in front of the compare
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= clamp_size(SIZE_W'(1024), MAX_WIDTH);
         height_ff   <= clamp_size(SIZE_W'(1024), MAX_HEIGHT);
         col_ff      <= '0;
         row_ff      <= '0;
         sel_ff      <= '0;
         row_base_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         sel_ff      <= sel_in;
         row_base_ff <= row_base_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_job_ff <= job_in;
         s1_val_ff <= in_frame ? req_data.error_value : '0;
         s1_sel_ff <= sel_ff;
      end
   end

   // Line store: one RAM per stored row, all read at the arrival column
   for (genvar b = 0; b < ROWS; b++) begin : g_store
      wlmf_ram #(
         .WIDTH(VALUE_W),
         .DEPTH(MAX_WIDTH)
      ) u_ram (
         .clock(clock),
         .we   (load && in_frame && (32'(sel_ff) == b)),
         .waddr(col_ff),
         .wdata(req_data.error_value),
         .re   (load),
         .raddr(col_ff),
         .rdata(ram_rdata[b])
      );
   end

   // Oldest row first: window row j comes from store row (sel+j) mod ROWS
   always_comb begin
      for (int j = 0; j < ROWS; j++) begin
         rot = (SELW+1)'(s1_sel_ff) + (SELW+1)'(j);
         if (32'(rot) >= ROWS) begin
            rot = (SELW+1)'(32'(rot) - ROWS);
         end
         column[j] = ram_rdata[rot[SELW-1:0]];
      end
      column[WIN-1] = s1_val_ff;
   end

   wlmf_window u_window (
      .clock  (clock),
      .advance(advance),
      .column (column),
      .job    (s1_job_ff),
      .hits   (hits)
   );

   wlmf_result_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (advance),
      .hits     (hits),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty compare stage");
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(width_ff))
      else $error("arrival column beyond map width");
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < 32'(height_ff) + REACH - 1)
      else $error("arrival row beyond drain rows");

endmodule
